// ===== design/altl_pkg.sv =====
// shared types, widths and codes for the arc-length table lookup
// no dependencies; imported by altl_div, arc_length_table_lookup_top and tb_top
`default_nettype none

package altl_pkg;

  // default sizes for the top-level parameters
  localparam int TABLE_DEPTH_DEF  = 1024;
  localparam int MAX_SEGMENTS_DEF = 256;

  // fixed field widths
  localparam int DIST_W  = 32;
  localparam int PARAM_W = 17;
  localparam int SEG_W   = 8;
  localparam int COUNT_W = 11;
  localparam int INDEX_W = 10;
  localparam int ENTRY_W = DIST_W + PARAM_W + SEG_W;

  // parameter value for one in q1.16
  localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(65536);

  // serial divider: span (17 bits) times distance offset (32 bits)
  localparam int DVD_W     = PARAM_W + DIST_W;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  // item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic [DIST_W-1:0]  distance;
    logic [PARAM_W-1:0] param;
    logic [SEG_W-1:0]   seg;
  } entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

// ===== design/arc_length_table_lookup_top.sv =====
// arc-length table lookup: table store, binary search sequencer and interpolation
// depends on altl_pkg, altl_ram and altl_div
`default_nettype none

// Arc-length table lookup. The table holds up to TABLE_DEPTH entries (distance
// q16.16, parameter q1.16, segment number) in one ram with a registered read port.
// A load word (kind 0) writes one entry; the block stays ready and produces no
// result. A query word (kind 1) runs a lower-bound binary search over the first
// entry_count entries, one probe per cycle on the ram read port, then reads the
// two neighbouring entries. A query outside the table gives parameter 0, segment
// 0 and restarted; a segment change or an empty interval gives the lower entry
// unchanged; otherwise the parameter is interpolated with a 17x32 multiply and a
// 49-step restoring divider. The search makes at most ceil(log2(n+1)) probes,
// n being the effective entry count (11 for a full table of 1024). in_ready is
// low for the whole query and rises with out_valid, so a new word is taken only
// once the query before it has finished. A finished result sits in an output
// register, so the next word can be taken while it waits for out_ready.
// entry_count is written by cfg_we and cfg_wdata; the user must write it only
// while the block is idle, which the block does not enforce. Values above
// TABLE_DEPTH act as TABLE_DEPTH. The table itself has no reset: entries read
// before being written return undefined data.
module arc_length_table_lookup_top
  import altl_pkg::*;
#(
  parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration
  input  wire logic               cfg_we,
  input  wire logic [COUNT_W-1:0] cfg_wdata,
  // input words
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               kind,
  input  wire logic [INDEX_W-1:0] entry_index,
  input  wire logic [DIST_W-1:0]  entry_distance,
  input  wire logic [PARAM_W-1:0] entry_param,
  input  wire logic [SEG_W-1:0]   entry_segment,
  input  wire logic [DIST_W-1:0]  query_distance,
  // result words
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [PARAM_W-1:0] curve_param,
  output logic      [SEG_W-1:0]   segment,
  output logic                    restarted
);

  // address and bound widths
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // sequencer codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_RD_HI  = 3'd3;
  localparam logic [2:0] S_CHECK  = 3'd4;
  localparam logic [2:0] S_MUL    = 3'd5;
  localparam logic [2:0] S_DIV    = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]         state;
  logic [COUNT_W-1:0] entry_count;
  logic [CW-1:0]      n_eff;

  // search state
  logic [DIST_W-1:0]  query;
  logic [CW-1:0]      lo;
  logic [CW-1:0]      hi;
  logic [CW-1:0]      lo_next;
  logic [CW-1:0]      hi_next;
  logic [AW-1:0]      mid;
  logic [AW-1:0]      mid_next;
  logic               search_more;

  // ram ports
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  entry_t             ram_wentry;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_entry;
  entry_t             ent_lo;

  // interpolation operands
  logic [DIST_W-1:0]  num;
  logic [DIST_W-1:0]  den;
  logic [PARAM_W-1:0] span;
  logic               dir_down;

  // result waiting for the output register
  logic [PARAM_W-1:0] res_param;
  logic [SEG_W-1:0]   res_seg;
  logic               res_restart;

  // divider
  logic               div_start;
  logic [DVD_W-1:0]   div_dividend;
  div_status_t        div_status;
  logic [PARAM_W-1:0] div_quot;

  logic               in_fire;
  logic               out_room;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_room = !out_valid || out_ready;
  assign rd_entry = entry_t'(ram_rdata);

  // counts above the table size act as the table size
  always_comb begin
    if (32'(entry_count) > 32'(TABLE_DEPTH)) begin
      n_eff = CW'(TABLE_DEPTH);
    end else begin
      n_eff = CW'(entry_count);
    end
  end

  // load path: out-of-range indexes dropped, parameter and segment clamped
  always_comb begin
    ram_we              = in_fire && (kind == KIND_LOAD)
                          && (32'(entry_index) < 32'(TABLE_DEPTH));
    ram_waddr           = AW'(32'(entry_index));
    ram_wentry.distance = entry_distance;
    ram_wentry.param    = (entry_param > PARAM_ONE) ? PARAM_ONE : entry_param;
    if (32'(entry_segment) >= 32'(MAX_SEGMENTS)) begin
      ram_wentry.seg = SEG_W'(MAX_SEGMENTS - 1);
    end else begin
      ram_wentry.seg = entry_segment;
    end
  end

  // one probe per cycle: compare the entry read last cycle, narrow the bounds
  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (state == S_SEARCH) begin
      if (rd_entry.distance < query) begin
        lo_next = CW'(mid) + CW'(1);
      end else begin
        hi_next = CW'(mid);
      end
    end
    search_more = lo_next < hi_next;
    mid_next    = AW'(({1'b0, lo_next} + {1'b0, hi_next}) >> 1);
  end

  // ram read address per sequencer step
  always_comb begin
    unique case (state)
      S_START:  ram_raddr = mid_next;
      S_SEARCH: ram_raddr = search_more ? mid_next : AW'(lo_next - CW'(1));
      S_RD_HI:  ram_raddr = AW'(lo);
      default:  ram_raddr = mid;
    endcase
  end

  // product feeds the divider load register directly
  assign div_start    = (state == S_MUL);
  assign div_dividend = DVD_W'(span) * DVD_W'(num);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= COUNT_W'(1);
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        entry_count <= cfg_wdata;
      end
      // output register loads from the done step, empties when taken
      if (state == S_DONE && out_room) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire && kind == KIND_QUERY) begin
            if (n_eff == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_START;
            end
          end
        end
        S_START: begin
          state <= S_SEARCH;
        end
        S_SEARCH: begin
          if (!search_more) begin
            // first entry or past the end: restart
            if (lo_next == '0 || lo_next >= n_eff) begin
              state <= S_DONE;
            end else begin
              state <= S_RD_HI;
            end
          end
        end
        S_RD_HI: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (ent_lo.seg != rd_entry.seg || rd_entry.distance <= ent_lo.distance) begin
            state <= S_DONE;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_status.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_room) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      lo <= '0;
      hi <= n_eff;
    end else begin
      lo <= lo_next;
      hi <= hi_next;
    end
    mid <= mid_next;
    unique case (state)
      S_IDLE: begin
        query       <= query_distance;
        res_param   <= '0;
        res_seg     <= '0;
        res_restart <= 1'b1;
      end
      S_SEARCH: begin
        if (!search_more && (lo_next == '0 || lo_next >= n_eff)) begin
          res_param   <= '0;
          res_seg     <= '0;
          res_restart <= 1'b1;
        end
      end
      S_RD_HI: begin
        ent_lo <= rd_entry;
      end
      S_CHECK: begin
        // segment change and zero-width interval both give the lower entry
        res_param   <= ent_lo.param;
        res_seg     <= ent_lo.seg;
        res_restart <= 1'b0;
        num         <= query - ent_lo.distance;
        den         <= rd_entry.distance - ent_lo.distance;
        dir_down    <= rd_entry.param < ent_lo.param;
        span        <= (rd_entry.param < ent_lo.param) ? ent_lo.param - rd_entry.param
                                                       : rd_entry.param - ent_lo.param;
      end
      S_DIV: begin
        if (div_status.done) begin
          res_param <= dir_down ? ent_lo.param - div_quot : ent_lo.param + div_quot;
        end
      end
      S_DONE: begin
        if (out_room) begin
          curve_param <= res_param;
          segment     <= res_seg;
          restarted   <= res_restart;
        end
      end
      default: begin
      end
    endcase
  end

  altl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  altl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (den),
    .status   (div_status),
    .quotient (div_quot)
  );

`ifndef ASSERT_OFF
  a_query_holds_input: assert property (@(posedge clk) disable iff (rst)
    in_fire && kind == KIND_QUERY |=> !in_ready)
    else $error("query accepted but block still ready");

  a_search_bounds: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |-> lo < hi && hi <= n_eff)
    else $error("search bounds out of order");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_status.done |-> state == S_DIV)
    else $error("divider finished outside the divide step");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result word raised outside the done step");
`endif

endmodule

`default_nettype wire

// ===== design/altl_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module altl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/altl_div.sv =====
// restoring serial divider, one quotient bit per cycle, low quotient bits kept
// depends on altl_pkg
`default_nettype none

module altl_div
  import altl_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [DVD_W-1:0]    dividend,
  input  wire logic [DIST_W-1:0]   divisor,
  output div_status_t              status,
  output logic      [PARAM_W-1:0]  quotient
);

  logic [DVD_W-1:0]     dvd;
  logic [DIST_W-1:0]    den;
  logic [DIST_W-1:0]    rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIST_W:0]      rem_sh;
  logic [DIST_W+1:0]    diff;
  logic                 ge;

  // shift in the next dividend bit and trial-subtract
  always_comb begin
    rem_sh = {rem, dvd[DVD_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den};
    ge     = ~diff[DIST_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status.busy <= 1'b0;
      status.done <= 1'b0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        status.busy <= 1'b1;
      end else if (status.busy && cnt == DIV_CNT_W'(1)) begin
        status.busy <= 1'b0;
        status.done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      den <= divisor;
      rem <= '0;
      cnt <= DIV_CNT_W'(DVD_W);
    end else if (status.busy) begin
      rem <= ge ? diff[DIST_W-1:0] : rem_sh[DIST_W-1:0];
      dvd <= {dvd[DVD_W-2:0], ge};
      cnt <= cnt - DIV_CNT_W'(1);
    end
  end

  // quotient bits accumulate where the dividend shifts out
  assign quotient = dvd[PARAM_W-1:0];

`ifndef ASSERT_OFF
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    status.done |-> $past(status.busy))
    else $error("divider done without a running division");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    !(start && status.busy))
    else $error("divider started while busy");

  a_busy_ends_in_done: assert property (@(posedge clk) disable iff (rst)
    status.busy && !start |=> status.busy || status.done)
    else $error("divider stopped without done");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench for arc_length_table_lookup_top: directed table walk, then random
// table builds and lookups checked against a behavioural model of the search and interpolation
// depends on altl_pkg and arc_length_table_lookup_top

module tb_top;
  import altl_pkg::*;

  localparam int          TABLE_DEPTH  = TABLE_DEPTH_DEF;
  localparam int          MAX_SEGMENTS = MAX_SEGMENTS_DEF;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int          SETTLE_CYCLES = 96;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          NUM_PHASES    = 15;
  localparam int          QUERIES_PER_PHASE = 40;
  localparam int          MAX_REPORTS   = 10;

  // entry counts visited by the random part, extremes included; the full table is
  // built once, the larger counts after it reuse what is already loaded
  localparam int unsigned PHASE_COUNTS [NUM_PHASES] =
    '{1, 0, 2, 3, 7, 16, 40, 100, 1024, 2047, 1023, 513, 5, 64, 1};

  // one lookup result as the block presents it
  typedef struct packed {
    logic [PARAM_W-1:0] curve_param;
    logic [SEG_W-1:0]   seg;
    logic               restarted;
  } lookup_t;

  // one input word, every field of the port set
  typedef struct packed {
    logic               kind;
    logic [INDEX_W-1:0] idx;
    logic [DIST_W-1:0]  distance;
    logic [PARAM_W-1:0] param;
    logic [SEG_W-1:0]   seg;
    logic [DIST_W-1:0]  qd;
  } word_t;

  // directed rows: a load, a query, or a new entry count (carried in qd)
  typedef enum logic [1:0] {ACT_LOAD, ACT_QUERY, ACT_COUNT} row_act_t;

  typedef struct packed {
    row_act_t           act;
    logic [INDEX_W-1:0] idx;
    logic [DIST_W-1:0]  distance;
    logic [PARAM_W-1:0] param;
    logic [SEG_W-1:0]   seg;
    logic [DIST_W-1:0]  qd;
    logic               typed;
    lookup_t            want;
  } dir_row_t;

  localparam lookup_t RESTART = '{17'd0, 8'd0, 1'b1};
  localparam lookup_t NONE    = '{17'd0, 8'd0, 1'b0};
  localparam int      DIR_ROWS = 24;

  // typed expectations only for restarts and segment changes; the rest go to the model
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // reset count of one: a single entry, every query falls outside it
    '{ACT_LOAD,  10'd0,    32'h0001_0000, 17'h00000, 8'd3,   32'h0,         1'b0, NONE},
    '{ACT_QUERY, 10'd0,    32'h0,         17'h0,     8'd0,   32'h0000_0000, 1'b1, RESTART},
    '{ACT_QUERY, 10'd0,    32'h0,         17'h0,     8'd0,   32'h0001_0000, 1'b1, RESTART},
    '{ACT_QUERY, 10'd0,    32'h0,         17'h0,     8'd0,   32'h0001_0001, 1'b1, RESTART},
    // four entries: two on segment 3, two on segment 255, over-range parameter clamps
    '{ACT_COUNT, 10'd0,    32'h0,         17'h0,     8'd0,   32'd4,         1'b0, NONE},
    '{ACT_LOAD,  10'd1,    32'h0002_0000, 17'h1FFFF, 8'd3,   32'h0,         1'b0, NONE},
    '{ACT_LOAD,  10'd2,    32'h0003_0000, 17'h04000, 8'd255, 32'h0,         1'b0, NONE},
    '{ACT_LOAD,  10'd3,    32'hFFFF_FFFF, 17'h00000, 8'd255, 32'h0,         1'b0, NONE},
    '{ACT_QUERY, 10'd0,    32'h0,         17'h0,     8'd0,   32'h0001_8000, 1'b0, NONE},
    '{ACT_QUERY, 10'd0,    32'h0,         17'h0,     8'd0,   32'h0002_0000, 1'b0, NONE},
    // segment change: lower entry comes back untouched
    '{ACT_QUERY, 10'd0,    32'h0,         17'h0,     8'd0,   32'h0002_0001, 1'b1,
      '{17'h10000, 8'd3, 1'b0}},
    '{ACT_QUERY, 10'd0,    32'h0,         17'h0,     8'd0,   32'h0003_0000, 1'b1,
      '{17'h10000, 8'd3, 1'b0}},
    // falling parameter across a very wide interval, then the top distance
    '{ACT_QUERY, 10'd0,    32'h0,         17'h0,     8'd0,   32'h0003_0001, 1'b0, NONE},
    '{ACT_QUERY, 10'd0,    32'h0,         17'h0,     8'd0,   32'hFFFF_FFFF, 1'b0, NONE},
    '{ACT_QUERY, 10'd0,    32'h0,         17'h0,     8'd0,   32'h8000_0000, 1'b0, NONE},
    // count of zero: nothing is valid, everything restarts
    '{ACT_COUNT, 10'd0,    32'h0,         17'h0,     8'd0,   32'd0,         1'b0, NONE},
    '{ACT_QUERY, 10'd0,    32'h0,         17'h0,     8'd0,   32'hFFFF_FFFF, 1'b1, RESTART},
    '{ACT_QUERY, 10'd0,    32'h0,         17'h0,     8'd0,   32'h0000_0000, 1'b1, RESTART},
    '{ACT_LOAD,  10'd1023, 32'hFFFF_FFFF, 17'h10000, 8'd255, 32'h0,         1'b0, NONE},
    // zero distance at the bottom of the table
    '{ACT_COUNT, 10'd0,    32'h0,         17'h0,     8'd0,   32'd3,         1'b0, NONE},
    '{ACT_LOAD,  10'd0,    32'h0000_0000, 17'h10000, 8'd3,   32'h0,         1'b0, NONE},
    '{ACT_QUERY, 10'd0,    32'h0,         17'h0,     8'd0,   32'h0000_0000, 1'b1, RESTART},
    '{ACT_QUERY, 10'd0,    32'h0,         17'h0,     8'd0,   32'h0000_0001, 1'b0, NONE},
    '{ACT_QUERY, 10'd0,    32'h0,         17'h0,     8'd0,   32'h0003_0001, 1'b1, RESTART}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;
  logic               in_valid;
  wire                in_ready;
  logic               kind;
  logic [INDEX_W-1:0] entry_index;
  logic [DIST_W-1:0]  entry_distance;
  logic [PARAM_W-1:0] entry_param;
  logic [SEG_W-1:0]   entry_segment;
  logic [DIST_W-1:0]  query_distance;
  wire                out_valid;
  logic               out_ready;
  wire [PARAM_W-1:0]  curve_param;
  wire [SEG_W-1:0]    segment;
  wire                restarted;

  // model copy of the table and the count register
  logic [DIST_W-1:0]  map_dist   [TABLE_DEPTH];
  logic [PARAM_W-1:0] map_param  [TABLE_DEPTH];
  logic [SEG_W-1:0]   map_seg    [TABLE_DEPTH];
  bit                 map_loaded [TABLE_DEPTH];
  logic [COUNT_W-1:0] live_count = COUNT_W'(1);

  lookup_t     lookups_due [$];
  int unsigned cycle_count = 0;
  int unsigned failures = 0;
  int unsigned reported = 0;
  int unsigned results_checked = 0;
  int unsigned loads_sent = 0;
  int unsigned queries_sent = 0;
  int unsigned count_writes = 0;
  int unsigned burst_left = 0;
  bit          sender_steady = 1'b0;
  bit          hold_off_req = 1'b0;

  arc_length_table_lookup_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .entry_index    (entry_index),
    .entry_distance (entry_distance),
    .entry_param    (entry_param),
    .entry_segment  (entry_segment),
    .query_distance (query_distance),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .curve_param    (curve_param),
    .segment        (segment),
    .restarted      (restarted)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d lookups outstanding",
               cycle_count, lookups_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // behavioural model
  // ---------------------------------------------------------------------------

  // write one entry, clamping the parameter to one and the segment to the top number
  function automatic void store_entry(word_t w);
    if (int'(w.idx) < TABLE_DEPTH) begin
      map_dist[w.idx]   = w.distance;
      map_param[w.idx]  = (w.param > PARAM_ONE) ? PARAM_ONE : w.param;
      map_seg[w.idx]    = (int'(w.seg) >= MAX_SEGMENTS) ? SEG_W'(MAX_SEGMENTS - 1) : w.seg;
      map_loaded[w.idx] = 1'b1;
    end
  endfunction

  // lower-bound search with the same probe order as a halving search
  function automatic int unsigned first_at_least(logic [DIST_W-1:0] q, int unsigned n);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (map_dist[mid] < q) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // expected result of a query at distance q
  function automatic lookup_t locate(logic [DIST_W-1:0] q);
    int unsigned n, i;
    logic [63:0] span, offs, gap_width, step;
    lookup_t r;
    r = NONE;
    n = (int'(live_count) > TABLE_DEPTH) ? TABLE_DEPTH : live_count;
    i = first_at_least(q, n);
    // outside the table on either side: restart from the beginning
    if (i == 0 || i >= n) return RESTART;
    r.seg = map_seg[i-1];
    r.curve_param = map_param[i-1];
    // interpolate only inside one segment and across a non-empty interval
    if (map_seg[i-1] == map_seg[i] && map_dist[i] > map_dist[i-1]) begin
      offs = 64'(q) - 64'(map_dist[i-1]);
      gap_width = 64'(map_dist[i]) - 64'(map_dist[i-1]);
      if (map_param[i] >= map_param[i-1]) begin
        span = 64'(map_param[i]) - 64'(map_param[i-1]);
        step = span * offs / gap_width;
        r.curve_param = map_param[i-1] + step[PARAM_W-1:0];
      end else begin
        span = 64'(map_param[i-1]) - 64'(map_param[i]);
        step = span * offs / gap_width;
        r.curve_param = map_param[i-1] - step[PARAM_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic bit all_loaded(int unsigned n);
    for (int unsigned k = 0; k < n; k++)
      if (!map_loaded[k]) return 1'b0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers; every task is entered and left just after a falling edge
  // ---------------------------------------------------------------------------

  // parameters mostly in range, some above one to hit the clamp, some at the ends
  function automatic logic [PARAM_W-1:0] random_param();
    case ($urandom_range(0, 7))
      0:       return PARAM_W'($urandom_range(0, 32'h1FFFF));
      1:       return $urandom_range(0, 1) ? PARAM_ONE : '0;
      default: return PARAM_W'($urandom_range(0, 32'h10000));
    endcase
  endfunction

  function automatic word_t random_word();
    word_t w;
    w.kind     = $urandom_range(0, 1) ? KIND_QUERY : KIND_LOAD;
    w.idx      = INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
    w.distance = $urandom();
    w.param    = random_param();
    w.seg      = SEG_W'($urandom_range(0, 255));
    w.qd       = $urandom();
    return w;
  endfunction

  // query aimed mostly inside intervals of the current table, with edges and noise
  function automatic word_t make_query(int unsigned n);
    word_t w;
    int unsigned i;
    logic [63:0] lo, hi;
    w = random_word();
    w.kind = KIND_QUERY;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
        if (n >= 2) begin
          i  = $urandom_range(1, n - 1);
          lo = 64'(map_dist[i-1]);
          hi = 64'(map_dist[i]);
          w.qd = (hi > lo) ? DIST_W'(lo + 1 + 64'($urandom()) % (hi - lo)) : DIST_W'(hi);
        end
      end
      12, 13, 14: if (n != 0) w.qd = map_dist[$urandom_range(0, n - 1)];
      15:         w.qd = '0;
      16:         w.qd = '1;
      17:         if (n != 0) w.qd = map_dist[n-1] + 1;
      default:    ;
    endcase
    return w;
  endfunction

  // present one word, hold it until taken, then record what it should cause
  task automatic offer_word(word_t w, bit typed, lookup_t want);
    in_valid       = 1'b1;
    kind           = w.kind;
    entry_index    = w.idx;
    entry_distance = w.distance;
    entry_param    = w.param;
    entry_segment  = w.seg;
    query_distance = w.qd;
    do @(posedge clk); while (!in_ready);
    if (w.kind == KIND_LOAD) begin
      store_entry(w);
      loads_sent++;
    end else begin
      lookups_due.insert(lookups_due.size(), typed ? want : locate(w.qd));
      queries_sent++;
    end
    @(negedge clk);
  endtask

  // bursts of back-to-back words, with random gaps between bursts unless the sender is steady
  task automatic send_word(word_t w, bit typed, lookup_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!sender_steady) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    offer_word(w, typed, want);
  endtask

  // stop sending, let every result out, then give a trailing load time to finish
  task automatic drain_results();
    in_valid = 1'b0;
    while (lookups_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_entry_count(logic [COUNT_W-1:0] v);
    drain_results();
    cfg_wdata = v;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we     = 1'b0;
    live_count = v;
    count_writes++;
  endtask

  // sorted distances from a random start, segments in runs, random parameters
  task automatic fill_table(int unsigned n);
    logic [63:0] d, max_step, step;
    logic [SEG_W-1:0] seg;
    word_t w;
    d = (n > 64) ? 64'($urandom_range(0, 32'hFFFF)) : 64'($urandom_range(0, 32'h7FFF_FFFF));
    max_step = (64'hFFFF_FFFF - d) / n;
    seg = SEG_W'($urandom_range(0, 255));
    for (int unsigned k = 0; k < n; k++) begin
      w = random_word();
      w.kind     = KIND_LOAD;
      w.idx      = INDEX_W'(k);
      w.distance = d[DIST_W-1:0];
      w.seg      = seg;
      send_word(w, 1'b0, NONE);
      case ($urandom_range(0, 7))
        0:       step = 0;
        1:       step = 1;
        2, 3:    step = $urandom_range(1, 256);
        default: step = $urandom_range(0, 32'(max_step));
      endcase
      d = d + ((step > max_step) ? max_step : step);
      if ($urandom_range(0, 3) == 0) seg = SEG_W'($urandom_range(0, 255));
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: stall pattern of its own, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int mode, left;
    mode = 0;
    left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        // long hold so that the output register fills and the input stalls
        hold_off_req = 1'b0;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(32, 256);
      end
      left--;
      case (mode)
        0:       out_ready = 1'b1;
        1:       out_ready = $urandom_range(0, 1);
        2:       out_ready = ($urandom_range(0, 3) == 0);
        default: out_ready = ((cycle_count % 7) < 3);
      endcase
    end
  end

  // every accepted result word against the oldest expectation
  always @(posedge clk) begin : result_check
    lookup_t got, due;
    if (!rst && out_valid && out_ready) begin
      got.curve_param = curve_param;
      got.seg         = segment;
      got.restarted   = restarted;
      if (lookups_due.size() == 0) begin
        failures++;
        if (reported < MAX_REPORTS)
          $display("unexpected result word: param %0d segment %0d restarted %0b",
                   got.curve_param, got.seg, got.restarted);
        reported++;
      end else begin
        due = lookups_due.pop_front();
        results_checked++;
        if (got.curve_param !== due.curve_param || got.seg !== due.seg ||
            got.restarted !== due.restarted) begin
          failures++;
          if (reported < MAX_REPORTS)
            $display("lookup %0d mismatch: expected param %0d segment %0d restarted %0b, %s",
                     results_checked, due.curve_param, due.seg, due.restarted,
                     $sformatf("got param %0d segment %0d restarted %0b",
                               got.curve_param, got.seg, got.restarted));
          reported++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t row;
    word_t w;
    int unsigned n;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    kind           = KIND_LOAD;
    entry_index    = '0;
    entry_distance = '0;
    entry_param    = '0;
    entry_segment  = '0;
    query_distance = '0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // directed walk
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIRECTED[r];
      if (row.act == ACT_COUNT) begin
        set_entry_count(row.qd[COUNT_W-1:0]);
      end else begin
        w = random_word();
        w.kind = (row.act == ACT_QUERY) ? KIND_QUERY : KIND_LOAD;
        if (row.act == ACT_QUERY) begin
          w.qd = row.qd;
        end else begin
          w.idx      = row.idx;
          w.distance = row.distance;
          w.param    = row.param;
          w.seg      = row.seg;
        end
        send_word(w, row.typed, row.want);
      end
    end

    // random phases: new count, fresh table where needed, then lookups with load noise
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_entry_count(COUNT_W'(PHASE_COUNTS[p]));
      n = (PHASE_COUNTS[p] > TABLE_DEPTH) ? TABLE_DEPTH : PHASE_COUNTS[p];
      if (n != 0 && (n <= 128 || !all_loaded(n))) fill_table(n);
      sender_steady = (p % 4 == 3);
      for (int q = 0; q < QUERIES_PER_PHASE; q++) begin
        if (p == 7 && q == 5) hold_off_req = 1'b1;
        if (p == 6 && q == 20) drain_results();
        if ($urandom_range(0, 9) == 0) begin
          w = random_word();
          w.kind = KIND_LOAD;
        end else begin
          w = make_query(n);
        end
        send_word(w, 1'b0, NONE);
      end
    end

    drain_results();
    if (lookups_due.size() != 0) failures++;
    $display("%0d load words and %0d lookups over %0d entry counts, table up to %0d entries",
             loads_sent, queries_sent, count_writes, TABLE_DEPTH);
    $display("%0d results checked, %0d failures", results_checked, failures);
    if (failures == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
